// File: hw/rtl/cpad_pkg.sv
// ----------------------------------------------------------------------------
// cpad_pkg: shared definitions of the touch period average detector
// Field widths, register codes, reset thresholds and the queue entry type.
// ----------------------------------------------------------------------------
package cpad_pkg;

  localparam int unsigned CH_FIELD_W   = 2;
  localparam int unsigned TS_W         = 32;
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned AVG_W        = 16;
  localparam int unsigned THRESH_W     = 16;
  localparam int unsigned MASK_W       = 4;
  localparam int unsigned NUM_THRESH   = 4;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam int unsigned DEF_WINDOW   = 256;
  localparam int unsigned DEF_CHANNELS = 4;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  typedef logic [THRESH_W-1:0] thresh_t;

  localparam thresh_t THRESH_RESET [NUM_THRESH] = '{
    THRESH_W'(130), THRESH_W'(130), THRESH_W'(580), THRESH_W'(140)
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH_CH0 = CFG_IDX_W'(0),
    REG_THRESH_CH1 = CFG_IDX_W'(1),
    REG_THRESH_CH2 = CFG_IDX_W'(2),
    REG_THRESH_CH3 = CFG_IDX_W'(3)
  } cfg_reg_e;

  // One classified edge, handed from the front end to the window engine.
  typedef struct packed {
    logic [CH_FIELD_W-1:0] ch;
    logic [PERIOD_W-1:0]   period;
  } edge_req_t;

  localparam int unsigned EDGE_REQ_W = $bits(edge_req_t);

endpackage

// File: hw/rtl/cpad_if.sv
// ----------------------------------------------------------------------------
// cpad_if: channel interfaces of the touch period average detector
// Edge input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface cpad_in_if import cpad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] channel;
  logic [TS_W-1:0]       timestamp_us;

  modport source (output valid, output channel, output timestamp_us, input ready);
  modport sink   (input valid, input channel, input timestamp_us, output ready);
endinterface

interface cpad_out_if import cpad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] channel_out;
  logic [PERIOD_W-1:0]   period_us;
  logic [AVG_W-1:0]      average_us;
  logic [MASK_W-1:0]     touched_mask;

  modport source (output valid, output channel_out, output period_us,
                  output average_us, output touched_mask, input ready);
  modport sink   (input valid, input channel_out, input period_us,
                  input average_us, input touched_mask, output ready);
endinterface

interface cpad_cfg_if import cpad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/cpad_ram.sv
// ----------------------------------------------------------------------------
// cpad_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cpad_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/cpad_fifo.sv
// ----------------------------------------------------------------------------
// cpad_fifo: short request queue
// Register-based FIFO between the front end and the window engine.
// ----------------------------------------------------------------------------
module cpad_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CNT_W'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// File: hw/rtl/cpad_front.sv
// ----------------------------------------------------------------------------
// cpad_front: edge front end
// Drop edges of absent channels, form the saturated period per channel.
// ----------------------------------------------------------------------------
module cpad_front import cpad_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpad_in_if.sink   in_i,
  output edge_req_t req_o,
  output logic      req_valid_o,
  input  logic      req_ready_i
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TS_W-1:0] last_q [CHANNELS];
  logic [CH_W-1:0] ch_idx;
  logic            ch_ok;
  logic            accept;
  logic [TS_W-1:0] diff;

  assign ch_ok  = (32'(in_i.channel) < CHANNELS);
  assign ch_idx = CH_W'(in_i.channel);
  assign diff   = in_i.timestamp_us - last_q[ch_idx];

  assign in_i.ready  = req_ready_i;
  assign accept      = in_i.valid && in_i.ready && ch_ok;
  assign req_valid_o = in_i.valid && ch_ok;
  assign req_o.ch    = in_i.channel;
  // Saturate the wrapped difference to the period width.
  assign req_o.period = (diff[TS_W-1:PERIOD_W] != '0) ? PERIOD_MAX : diff[PERIOD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_q[i] <= '0;
      end
    end else if (accept) begin
      last_q[ch_idx] <= in_i.timestamp_us;
    end
  end

endmodule

// File: hw/rtl/cpad_back.sv
// ----------------------------------------------------------------------------
// cpad_back: window engine
// Ring window update, running sum, divide by window, touch mask, result.
// ----------------------------------------------------------------------------
module cpad_back import cpad_pkg::*; #(
  parameter int unsigned WINDOW   = DEF_WINDOW,
  parameter int unsigned CHANNELS = DEF_CHANNELS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  edge_req_t  req_i,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  thresh_t    thresh_i [NUM_THRESH],
  cpad_out_if.source out_o
);

  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IDX_W   = $clog2(WINDOW);
  localparam int unsigned ADDR_W  = CH_W + IDX_W;
  localparam int unsigned SUM_W   = IDX_W + PERIOD_W;
  localparam int unsigned RECIP_W = PERIOD_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned QW_W    = AVG_W + IDX_W + 1;
  localparam longint unsigned RECIP = (longint'(1) << SUM_W) / WINDOW;
  localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
  localparam logic [IDX_W:0]     WIN_C    = (IDX_W + 1)'(WINDOW);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(WINDOW - 1);

  // Per-channel state
  logic [IDX_W-1:0] idx_q  [CHANNELS];
  logic             wrap_q [CHANNELS];
  logic [SUM_W-1:0] sum_q  [CHANNELS];
  logic [AVG_W-1:0] avg_q  [CHANNELS];

  logic adv, pop;
  logic b_valid_q, c_valid_q, d_valid_q, e_valid_q;

  // Stage A: pop, read the slot about to be replaced
  logic [CH_W-1:0]  a_chi;
  logic [IDX_W-1:0] a_slot;

  // Stage B: window update
  logic [CH_FIELD_W-1:0] b_ch_q;
  logic [PERIOD_W-1:0]   b_period_q;
  logic [ADDR_W-1:0]     b_addr_q;
  logic                  b_wrap_q;
  logic [CH_W-1:0]       b_chi;
  logic [PERIOD_W-1:0]   rdata, b_old;
  logic [SUM_W-1:0]      b_sum;

  // Stage C: reciprocal multiply
  logic [CH_FIELD_W-1:0] c_ch_q;
  logic [PERIOD_W-1:0]   c_period_q;
  logic [SUM_W-1:0]      c_sum_q;

  // Stage D: quotient correction
  logic [CH_FIELD_W-1:0] d_ch_q;
  logic [PERIOD_W-1:0]   d_period_q;
  logic [SUM_W-1:0]      d_sum_q;
  logic [PROD_W-1:0]     d_prod_q;
  logic [CH_W-1:0]       d_chi;
  logic [AVG_W-1:0]      d_qest, d_avg;
  logic [QW_W-1:0]       d_qw;
  logic [SUM_W-1:0]      d_rem;

  // Stage E: result register
  logic [CH_FIELD_W-1:0] e_ch_q;
  logic [PERIOD_W-1:0]   e_period_q;
  logic [AVG_W-1:0]      e_avg_q;
  logic [MASK_W-1:0]     mask;

  // The whole pipe moves together; it holds while a result waits.
  assign adv         = !e_valid_q || out_o.ready;
  assign req_ready_o = adv;
  assign pop         = adv && req_valid_i;

  assign a_chi  = CH_W'(req_i.ch);
  assign a_slot = idx_q[a_chi];

  cpad_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (2 ** ADDR_W)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (adv && b_valid_q),
    .waddr_i (b_addr_q),
    .wdata_i (b_period_q),
    .re_i    (pop),
    .raddr_i ({a_chi, a_slot}),
    .rdata_o (rdata)
  );

  // A slot not yet written since reset reads as zero.
  assign b_chi = CH_W'(b_ch_q);
  assign b_old = b_wrap_q ? rdata : '0;
  assign b_sum = sum_q[b_chi] - SUM_W'(b_old) + SUM_W'(b_period_q);

  // Floor-reciprocal estimate is low by at most one; fix with one compare.
  assign d_chi  = CH_W'(d_ch_q);
  assign d_qest = d_prod_q[SUM_W +: AVG_W];
  assign d_qw   = QW_W'(d_qest) * QW_W'(WIN_C);
  assign d_rem  = d_sum_q - SUM_W'(d_qw);
  assign d_avg  = (d_rem >= SUM_W'(WINDOW)) ? d_qest + AVG_W'(1) : d_qest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        idx_q[i]  <= '0;
        wrap_q[i] <= 1'b0;
        sum_q[i]  <= '0;
        avg_q[i]  <= '0;
      end
    end else if (adv) begin
      b_valid_q <= req_valid_i;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      if (pop) begin
        if (a_slot == LAST_IDX) begin
          idx_q[a_chi]  <= '0;
          wrap_q[a_chi] <= 1'b1;
        end else begin
          idx_q[a_chi] <= a_slot + IDX_W'(1);
        end
      end
      if (b_valid_q) begin
        sum_q[b_chi] <= b_sum;
      end
      if (d_valid_q) begin
        avg_q[d_chi] <= d_avg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_ch_q     <= req_i.ch;
      b_period_q <= req_i.period;
      b_addr_q   <= {a_chi, a_slot};
      b_wrap_q   <= wrap_q[a_chi];
      c_ch_q     <= b_ch_q;
      c_period_q <= b_period_q;
      c_sum_q    <= b_sum;
      d_ch_q     <= c_ch_q;
      d_period_q <= c_period_q;
      d_sum_q    <= c_sum_q;
      d_prod_q   <= PROD_W'(c_sum_q) * PROD_W'(RECIP_C);
      e_ch_q     <= d_ch_q;
      e_period_q <= d_period_q;
      e_avg_q    <= d_avg;
    end
  end

  // Averages stand still while a result waits, so the mask is stable.
  for (genvar n = 0; n < NUM_THRESH; n++) begin : g_mask
    if (n < CHANNELS) begin : g_on
      assign mask[n] = (avg_q[n] > thresh_i[n]);
    end else begin : g_off
      assign mask[n] = 1'b0;
    end
  end

  assign out_o.valid        = e_valid_q;
  assign out_o.channel_out  = e_ch_q;
  assign out_o.period_us    = e_period_q;
  assign out_o.average_us   = e_avg_q;
  assign out_o.touched_mask = mask;

endmodule

// File: hw/rtl/captouch_period_average_detector_unit.sv
// ----------------------------------------------------------------------------
// captouch_period_average_detector_unit: capacitive touch period averager
// Per-channel edge periods, moving average over a ring window, touch mask.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   edge requests: channel and microsecond timestamp. Edges of a
//          channel at or above CHANNELS are taken and dropped silently.
//   out_o  one result request per kept edge: channel, saturated period,
//          truncated window average and the touch mask of all channels.
//   cfg_i  threshold writes, index 0 to 3; other indexes are ignored.
//          Always ready; write only while no edge is in flight.
// Timing: a kept edge is registered in the queue and then in stages B, C, D
//   and E before it is presented on out_o. One edge per cycle sustained while
//   out_o takes results: the front end, the window RAM read-modify-write
//   (read in stage A, written in stage B) and the two-stage divide by WINDOW
//   are all pipelined.
// Reset: thresholds return to 130/130/580/140, last stamps, sums, window
//   indexes and averages clear. Window slots not yet written since reset
//   read as zero through a per-channel wrap flag, so no clearing pass runs.
// Stall: while out_o is not ready the engine holds; the two-entry queue
//   keeps taking edges until it fills, then in_i.ready drops.
// ----------------------------------------------------------------------------
module captouch_period_average_detector_unit import cpad_pkg::*; #(
  parameter int unsigned WINDOW   = DEF_WINDOW,
  parameter int unsigned CHANNELS = DEF_CHANNELS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpad_in_if.sink    in_i,
  cpad_out_if.source out_o,
  cpad_cfg_if.sink   cfg_i
);

  thresh_t   thresh_q [NUM_THRESH];
  edge_req_t front_req, back_req;
  logic      front_valid, front_ready;
  logic      back_valid, back_ready;

  // Threshold registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THRESH; i++) begin
        thresh_q[i] <= THRESH_RESET[i];
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_THRESH_CH0: thresh_q[0] <= cfg_i.data;
        REG_THRESH_CH1: thresh_q[1] <= cfg_i.data;
        REG_THRESH_CH2: thresh_q[2] <= cfg_i.data;
        REG_THRESH_CH3: thresh_q[3] <= cfg_i.data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Front end: classify edges, form periods
  cpad_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .req_o       (front_req),
    .req_valid_o (front_valid),
    .req_ready_i (front_ready)
  );

  // Decouple the front end from the window engine
  cpad_fifo #(
    .WIDTH (EDGE_REQ_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_req),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_data_o  (back_req)
  );

  // Window engine: ring window, running sum, average, mask
  cpad_back #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (back_req),
    .req_valid_i (back_valid),
    .req_ready_o (back_ready),
    .thresh_i    (thresh_q),
    .out_o       (out_o)
  );

endmodule
